>>> hdl/m2u_pkg.sv
// ----------------------------------------------------------------------------
// m2u_pkg
// Shared types, codes and value scaling helpers for the MIDI 1.0 byte stream
// to UMP converter.
// ----------------------------------------------------------------------------
package m2u_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIDI2_OUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP     = 8'd1;

  // UMP message types
  localparam logic [3:0] MT_SYS  = 4'h1;
  localparam logic [3:0] MT_M1   = 4'h2;
  localparam logic [3:0] MT_SX7  = 4'h3;
  localparam logic [3:0] MT_M2   = 4'h4;

  // status nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY_AT  = 4'hA;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_CHAN_AT  = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [3:0] ST_RPN      = 4'h2;
  localparam logic [3:0] ST_NRPN     = 4'h3;

  // SysEx packet status codes
  localparam logic [3:0] SX_COMPLETE = 4'h0;
  localparam logic [3:0] SX_END      = 4'h3;

  // SysEx phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_CONT  = 2'd2;

  // status bytes
  localparam logic [7:0] B_SX_START   = 8'hF0;
  localparam logic [7:0] B_MTC        = 8'hF1;
  localparam logic [7:0] B_SONG_POS   = 8'hF2;
  localparam logic [7:0] B_SONG_SEL   = 8'hF3;
  localparam logic [7:0] B_TUNE       = 8'hF6;
  localparam logic [7:0] B_SX_STOP    = 8'hF7;
  localparam logic [7:0] B_CLOCK      = 8'hF8;
  localparam logic [7:0] UNSET        = 8'hFF;

  // controller numbers
  localparam logic [7:0] CC_BANK_MSB  = 8'd0;
  localparam logic [7:0] CC_DATA_MSB  = 8'd6;
  localparam logic [7:0] CC_BANK_LSB  = 8'd32;
  localparam logic [7:0] CC_DATA_LSB  = 8'd38;
  localparam logic [7:0] CC_NRPN_LSB  = 8'd98;
  localparam logic [7:0] CC_NRPN_MSB  = 8'd99;
  localparam logic [7:0] CC_RPN_LSB   = 8'd100;
  localparam logic [7:0] CC_RPN_MSB   = 8'd101;

  localparam logic [2:0] SX_MAX = 3'd6;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } ump_ent_t;

  typedef struct packed {
    logic [1:0] n;
    ump_ent_t   e0;
    ump_ent_t   e1;
  } push_t;

  // min-center-max upscale, 7 -> 16 bits
  function automatic logic [15:0] up7_16(input logic [7:0] v);
    logic [5:0] r;
    logic [15:0] o;
    r = v[5:0];
    o = {v[6:0], 9'b0};
    if (v[6:0] > 7'd64) o = o | {7'b0, r, 3'b0} | {13'b0, r[5:3]};
    return o;
  endfunction

  // 7 -> 32 bits
  function automatic logic [31:0] up7_32(input logic [7:0] v);
    logic [5:0] r;
    logic [31:0] o;
    r = v[5:0];
    o = {v[6:0], 25'b0};
    if (v[6:0] > 7'd64)
      o = o | {7'b0, r, 19'b0} | {13'b0, r, 13'b0} | {19'b0, r, 7'b0}
            | {25'b0, r, 1'b0} | {31'b0, r[5]};
    return o;
  endfunction

  // 14 -> 32 bits
  function automatic logic [31:0] up14_32(input logic [13:0] v);
    logic [12:0] r;
    logic [31:0] o;
    r = v[12:0];
    o = {v, 18'b0};
    if (v > 14'd8192) o = o | {14'b0, r, 5'b0} | {27'b0, r[12:8]};
    return o;
  endfunction

endpackage

>>> hdl/m2u_if.sv
// ----------------------------------------------------------------------------
// m2u interfaces
// Valid/ready channels for stream bytes, UMP words and register writes.
// ----------------------------------------------------------------------------
interface m2u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface m2u_ump_if;
  logic        valid;
  logic        ready;
  logic [31:0] ump_word;
  logic        last_word;
  modport source (output valid, output ump_word, output last_word, input ready);
  modport sink   (input valid, input ump_word, input last_word, output ready);
endinterface

interface m2u_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [m2u_pkg::CFG_IDX_W-1:0] index;
  logic [m2u_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/m2u_ofifo.sv
// ----------------------------------------------------------------------------
// m2u_ofifo
// Four-entry word queue; takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
module m2u_ofifo (
  input  logic              clk,
  input  logic              rst,
  input  m2u_pkg::push_t    push,
  output logic              room,
  m2u_ump_if.source         ump
);

  m2u_pkg::ump_ent_t mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       pop;

  assign pop  = ump.valid && ump.ready;
  assign room = (count <= 3'd2);
  assign ump.valid     = (count != 3'd0);
  assign ump.ump_word  = mem[rp].word;
  assign ump.last_word = mem[rp].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.n;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push.n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp] <= push.e0;
    if (push.n == 2'd2) mem[wp + 2'd1] <= push.e1;
  end

endmodule

>>> hdl/midi1_bytestream_to_ump.sv
// ----------------------------------------------------------------------------
// midi1_bytestream_to_ump
// MIDI 1.0 byte stream to Universal MIDI Packet words (MIDI 1.0 or 2.0 voice).
// ----------------------------------------------------------------------------
// Flow: a byte is registered at acceptance and converted into the queue once
//   the queue has room for two words; its first word is offered straight
//   from the queue.
// Throughput: one byte per cycle while the output queue has room for two words;
//   a byte that yields two words drains at one word per cycle while ump.ready is high.
// Reset: synchronous; clears config, running status, SysEx state, input byte and queue,
//   sets per-channel bank and parameter registers to unset, RPN flags to 0.
module midi1_bytestream_to_ump (
  input  logic      clk,
  input  logic      rst,
  m2u_byte_if.sink  src,
  m2u_ump_if.source ump,
  m2u_cfg_if.sink   cfg
);

  // config registers
  logic       midi2_out;
  logic [3:0] group;

  // input register
  logic [7:0] byte_q;
  logic       byte_vld;
  logic       room;
  logic       go;

  // stream state
  logic [7:0] running_status, rs_next;
  logic [7:0] held_data, held_next;
  logic [1:0] sx_phase, phase_next;
  logic [2:0] sx_count, cnt_next;
  logic [6:0] sx_bytes [6];
  logic       sx_clr, sx_we;
  logic [2:0] sx_idx;

  // per-channel controller state
  logic [7:0] bank_high [16];
  logic [7:0] bank_low [16];
  logic [7:0] param_high [16];
  logic [7:0] param_low [16];
  logic [7:0] param_value_high [16];
  logic       param_registered [16];
  logic       bh_we, bl_we, ph_we, pl_we, pvh_we, preg_we, preg_val;

  // translation operands
  logic       t_do;
  logic [7:0] t_b0, t_b1, t_b2;
  logic [3:0] ch, st_e;
  logic [7:0] hi7;
  logic [1:0] n;
  logic [31:0] w0, w1;
  m2u_pkg::push_t push;

  assign cfg.ready = 1'b1;
  assign go        = byte_vld && room;
  assign src.ready = !byte_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      midi2_out <= 1'b0;
      group     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        m2u_pkg::REG_MIDI2_OUT: midi2_out <= cfg.data[0];
        m2u_pkg::REG_GROUP:     group     <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (src.valid && src.ready) begin
      byte_vld <= 1'b1;
    end else if (go) begin
      byte_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) byte_q <= src.in_byte;
  end

  // stream parsing and translation for the registered byte
  always_comb begin
    rs_next    = running_status;
    held_next  = held_data;
    phase_next = sx_phase;
    cnt_next   = sx_count;
    sx_clr     = 1'b0;
    sx_we      = 1'b0;
    sx_idx     = sx_count;
    n          = 2'd0;
    w0         = '0;
    w1         = '0;
    t_do       = 1'b0;
    t_b0       = running_status;
    t_b1       = '0;
    t_b2       = '0;
    bh_we = 1'b0; bl_we = 1'b0; ph_we = 1'b0; pl_we = 1'b0;
    pvh_we = 1'b0; preg_we = 1'b0; preg_val = 1'b0;
    if (go) begin
      if (byte_q == m2u_pkg::B_TUNE || byte_q >= m2u_pkg::B_CLOCK) begin
        // realtime and tune request pass straight through
        t_do = 1'b1;
        t_b0 = byte_q;
      end else if (byte_q[7]) begin
        rs_next   = byte_q;
        held_next = m2u_pkg::UNSET;
        if (byte_q == m2u_pkg::B_SX_START) begin
          phase_next = m2u_pkg::PH_FIRST;
          cnt_next   = '0;
          sx_clr     = 1'b1;
        end else if (byte_q == m2u_pkg::B_SX_STOP) begin
          // closing packet; a stray end still emits one
          n  = 2'd2;
          w0 = {m2u_pkg::MT_SX7, group,
                (sx_phase == m2u_pkg::PH_FIRST) ? m2u_pkg::SX_COMPLETE : m2u_pkg::SX_END,
                1'b0, sx_count, 1'b0, sx_bytes[0], 1'b0, sx_bytes[1]};
          w1 = {1'b0, sx_bytes[2], 1'b0, sx_bytes[3], 1'b0, sx_bytes[4],
                1'b0, sx_bytes[5]};
          sx_clr     = 1'b1;
          phase_next = m2u_pkg::PH_IDLE;
        end
      end else if (sx_phase != m2u_pkg::PH_IDLE) begin
        sx_we = 1'b1;
        if (sx_count >= m2u_pkg::SX_MAX) begin
          // full packet goes out before this byte is stored
          n  = 2'd2;
          w0 = {m2u_pkg::MT_SX7, group, 2'b0, sx_phase, 1'b0, m2u_pkg::SX_MAX,
                1'b0, sx_bytes[0], 1'b0, sx_bytes[1]};
          w1 = {1'b0, sx_bytes[2], 1'b0, sx_bytes[3], 1'b0, sx_bytes[4],
                1'b0, sx_bytes[5]};
          sx_clr     = 1'b1;
          phase_next = m2u_pkg::PH_CONT;
          sx_idx     = '0;
          cnt_next   = 3'd1;
        end else begin
          cnt_next = sx_count + 3'd1;
        end
      end else if (held_data != m2u_pkg::UNSET) begin
        held_next = m2u_pkg::UNSET;
        t_do = 1'b1;
        t_b1 = held_data;
        t_b2 = byte_q;
      end else if (running_status != 8'd0) begin
        if (running_status[7:4] == m2u_pkg::ST_PROGRAM ||
            running_status[7:4] == m2u_pkg::ST_CHAN_AT ||
            running_status == m2u_pkg::B_MTC || running_status == m2u_pkg::B_SONG_SEL) begin
          t_do = 1'b1;
          t_b1 = byte_q;
        end else if (running_status < m2u_pkg::B_SX_START ||
                     running_status == m2u_pkg::B_SONG_POS) begin
          held_next = byte_q;
        end
      end
    end

    ch   = t_b0[3:0];
    st_e = (t_b0[7:4] == m2u_pkg::ST_NOTE_ON && t_b2 == 8'd0) ?
           m2u_pkg::ST_NOTE_OFF : t_b0[7:4];
    hi7  = (param_value_high[ch] == m2u_pkg::UNSET) ? 8'd0 : {1'b0, param_value_high[ch][6:0]};

    if (t_do) begin
      if (t_b0 >= m2u_pkg::B_MTC) begin
        n  = 2'd1;
        w0 = {m2u_pkg::MT_SYS, group, t_b0, t_b1, t_b2};
      end else if (t_b0 < 8'h80 || t_b0 == m2u_pkg::B_SX_START) begin
        n = 2'd0;
      end else if (!midi2_out) begin
        n  = 2'd1;
        w0 = {m2u_pkg::MT_M1, group, t_b0, t_b1, t_b2};
      end else begin
        n  = 2'd2;
        w0 = {m2u_pkg::MT_M2, group, st_e, ch, 16'b0};
        case (st_e)
          m2u_pkg::ST_NOTE_OFF, m2u_pkg::ST_NOTE_ON: begin
            w0[15:8] = t_b1;
            w1 = {m2u_pkg::up7_16(t_b2), 16'b0};
          end
          m2u_pkg::ST_POLY_AT: begin
            w0[15:8] = t_b1;
            w1 = m2u_pkg::up7_32(t_b2);
          end
          m2u_pkg::ST_PROGRAM: begin
            if (bank_high[ch] != m2u_pkg::UNSET && bank_low[ch] != m2u_pkg::UNSET) begin
              w0[0] = 1'b1;
              w1    = {16'b0, bank_high[ch], bank_low[ch]};
            end
            w1[31:24] = {1'b0, t_b1[6:0]};
          end
          m2u_pkg::ST_CHAN_AT: w1 = m2u_pkg::up7_32(t_b1);
          m2u_pkg::ST_BEND:    w1 = m2u_pkg::up14_32({t_b2[6:0], t_b1[6:0]});
          m2u_pkg::ST_CTRL: begin
            case (t_b1)
              m2u_pkg::CC_BANK_MSB: begin n = 2'd0; bh_we = 1'b1; end
              m2u_pkg::CC_BANK_LSB: begin n = 2'd0; bl_we = 1'b1; end
              m2u_pkg::CC_NRPN_MSB: begin n = 2'd0; preg_we = 1'b1; ph_we = 1'b1; end
              m2u_pkg::CC_NRPN_LSB: begin n = 2'd0; preg_we = 1'b1; pl_we = 1'b1; end
              m2u_pkg::CC_RPN_MSB: begin
                n = 2'd0; preg_we = 1'b1; preg_val = 1'b1; ph_we = 1'b1;
              end
              m2u_pkg::CC_RPN_LSB: begin
                n = 2'd0; preg_we = 1'b1; preg_val = 1'b1; pl_we = 1'b1;
              end
              m2u_pkg::CC_DATA_MSB: begin
                n = 2'd0;
                if (param_high[ch] != m2u_pkg::UNSET && param_low[ch] != m2u_pkg::UNSET) begin
                  // RPN 0/0 (pitch bend range) and RPN 0/6 take the MSB alone
                  if (param_registered[ch] && param_high[ch] == 8'd0 &&
                      (param_low[ch] == 8'd0 || param_low[ch] == m2u_pkg::CC_DATA_MSB)) begin
                    n  = 2'd2;
                    w0 = {m2u_pkg::MT_M2, group, m2u_pkg::ST_RPN, ch,
                          param_high[ch], param_low[ch]};
                    w1 = m2u_pkg::up14_32({t_b2[6:0], 7'b0});
                  end else begin
                    pvh_we = 1'b1;
                  end
                end
              end
              m2u_pkg::CC_DATA_LSB: begin
                n = 2'd0;
                if (param_high[ch] != m2u_pkg::UNSET && param_low[ch] != m2u_pkg::UNSET) begin
                  n  = 2'd2;
                  w0 = {m2u_pkg::MT_M2, group,
                        param_registered[ch] ? m2u_pkg::ST_RPN : m2u_pkg::ST_NRPN, ch,
                        param_high[ch], param_low[ch]};
                  w1 = m2u_pkg::up14_32({hi7[6:0], t_b2[6:0]});
                end
              end
              default: begin
                w0[15:8] = t_b1;
                w1 = m2u_pkg::up7_32(t_b2);
              end
            endcase
          end
          default: n = 2'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= '0;
      held_data      <= m2u_pkg::UNSET;
      sx_phase       <= m2u_pkg::PH_IDLE;
      sx_count       <= '0;
      for (int i = 0; i < 6; i++) sx_bytes[i] <= '0;
      for (int i = 0; i < 16; i++) begin
        bank_high[i]        <= m2u_pkg::UNSET;
        bank_low[i]         <= m2u_pkg::UNSET;
        param_high[i]       <= m2u_pkg::UNSET;
        param_low[i]        <= m2u_pkg::UNSET;
        param_value_high[i] <= m2u_pkg::UNSET;
        param_registered[i] <= 1'b0;
      end
    end else begin
      running_status <= rs_next;
      held_data      <= held_next;
      sx_phase       <= phase_next;
      sx_count       <= cnt_next;
      // a byte stored right after a full packet lands in slot 0 of the cleared buffer
      for (int i = 0; i < 6; i++) begin
        if (sx_we && sx_idx == 3'(i)) sx_bytes[i] <= byte_q[6:0];
        else if (sx_clr) sx_bytes[i] <= '0;
      end
      if (bh_we)   bank_high[ch]        <= t_b2;
      if (bl_we)   bank_low[ch]         <= t_b2;
      if (ph_we)   param_high[ch]       <= t_b2;
      if (pl_we)   param_low[ch]        <= t_b2;
      if (pvh_we)  param_value_high[ch] <= t_b2;
      if (preg_we) param_registered[ch] <= preg_val;
    end
  end

  assign push.n  = n;
  assign push.e0 = '{word: w0, last: (n == 2'd1)};
  assign push.e1 = '{word: w1, last: 1'b1};

  m2u_ofifo u_ofifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .ump  (ump)
  );

endmodule

>>> hdl/m2u_chk.sv
// ----------------------------------------------------------------------------
// m2u_chk
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module m2u_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        out_last
);

  // a stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled word changed");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("word offered after reset");

  // second word of a pair is already queued when the first is taken
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second word of packet missing");

endmodule

bind midi1_bytestream_to_ump m2u_chk u_m2u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (ump.valid),
  .out_ready (ump.ready),
  .out_word  (ump.ump_word),
  .out_last  (ump.last_word)
);

>>> tb/tb_midi1_bytestream_to_ump.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds MIDI 1.0 stream bytes to midi1_bytestream_to_ump and checks every UMP
// word against a behavioral predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts UMP words for each accepted byte and checks words as they arrive.
  class ump_scoreboard;
    bit          m2_mode;
    logic [3:0]  group;
    logic [7:0]  run_status, held;
    logic [7:0]  bank_hi [16], bank_lo [16], par_hi [16], par_lo [16], val_hi [16];
    bit          par_rpn [16];
    logic [1:0]  sx_phase;
    int          sx_cnt;
    logic [6:0]  sx_buf [6];
    logic [32:0] pending [$];   // {last, word}
    int          errors;

    function void clear();
      m2_mode = 0; group = 0; run_status = 0; held = m2u_pkg::UNSET;
      for (int i = 0; i < 16; i++) begin
        bank_hi[i] = m2u_pkg::UNSET; bank_lo[i] = m2u_pkg::UNSET;
        par_hi[i] = m2u_pkg::UNSET; par_lo[i] = m2u_pkg::UNSET;
        val_hi[i] = m2u_pkg::UNSET; par_rpn[i] = 0;
      end
      sx_phase = m2u_pkg::PH_IDLE; sx_cnt = 0;
      for (int i = 0; i < 6; i++) sx_buf[i] = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == m2u_pkg::REG_MIDI2_OUT) m2_mode = val[0];
      else if (idx == m2u_pkg::REG_GROUP) group = val[3:0];
    endfunction

    function logic [31:0] head(logic [3:0] mt);
      return {mt, group, 24'h0};
    endfunction

    // min-center-max bit repeat
    function logic [31:0] scale(logic [31:0] v, int sb, int db);
      int sh, rb;
      logic [31:0] o, rep;
      sh = db - sb; rb = sb - 1;
      v = v & ((32'd1 << sb) - 1);
      o = v << sh;
      if (v <= (32'd1 << rb)) return o;
      rep = v & ((32'd1 << rb) - 1);
      if (sh > rb) rep = rep << (sh - rb);
      else rep = rep >> (rb - sh);
      while (rep != 0) begin
        o |= rep;
        rep = rep >> rb;
      end
      return o;
    endfunction

    function void push2(logic [31:0] w0, logic [31:0] w1);
      pending.push_back({1'b0, w0});
      pending.push_back({1'b1, w1});
    endfunction

    function void sx_emit(logic [3:0] st, logic [3:0] n);
      push2(head(m2u_pkg::MT_SX7) | {8'h0, st, n, 1'b0, sx_buf[0], 1'b0, sx_buf[1]},
            {1'b0, sx_buf[2], 1'b0, sx_buf[3], 1'b0, sx_buf[4], 1'b0, sx_buf[5]});
      for (int i = 0; i < 6; i++) sx_buf[i] = 0;
    endfunction

    function void param_emit(int ch, logic [13:0] v);
      logic [3:0] st;
      st = par_rpn[ch] ? m2u_pkg::ST_RPN : m2u_pkg::ST_NRPN;
      push2(head(m2u_pkg::MT_M2) | {8'h0, st, ch[3:0], par_hi[ch], par_lo[ch]},
            scale(v, 14, 32));
    endfunction

    function void convert(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      logic [3:0] st;
      int ch;
      logic [31:0] w0, w1;
      logic [6:0] hi;
      st = b0[7:4]; ch = b0[3:0]; w1 = 0;
      if (b0 >= m2u_pkg::B_MTC) begin
        pending.push_back({1'b1, head(m2u_pkg::MT_SYS) | {8'h0, b0, b1, b2}});
        return;
      end
      if (st < m2u_pkg::ST_NOTE_OFF || st > m2u_pkg::ST_BEND) return;
      if (!m2_mode) begin
        pending.push_back({1'b1, head(m2u_pkg::MT_M1) | {8'h0, b0, b1, b2}});
        return;
      end
      if (st == m2u_pkg::ST_NOTE_ON && b2 == 0) st = m2u_pkg::ST_NOTE_OFF;
      w0 = head(m2u_pkg::MT_M2) | {8'h0, st, ch[3:0], 16'h0};
      case (st)
        m2u_pkg::ST_NOTE_OFF, m2u_pkg::ST_NOTE_ON: begin
          w0 |= {16'h0, b1, 8'h0};
          w1 = scale(b2, 7, 16) << 16;
        end
        m2u_pkg::ST_POLY_AT: begin
          w0 |= {16'h0, b1, 8'h0};
          w1 = scale(b2, 7, 32);
        end
        m2u_pkg::ST_PROGRAM: begin
          if (bank_hi[ch] != m2u_pkg::UNSET && bank_lo[ch] != m2u_pkg::UNSET) begin
            w0 |= 32'd1;
            w1 = {16'h0, bank_hi[ch], bank_lo[ch]};
          end
          w1 |= {1'b0, b1[6:0], 24'h0};
        end
        m2u_pkg::ST_CHAN_AT: w1 = scale(b1, 7, 32);
        m2u_pkg::ST_BEND: w1 = scale({b2[6:0], b1[6:0]}, 14, 32);
        default: begin
          case (b1)
            m2u_pkg::CC_BANK_MSB: begin bank_hi[ch] = b2; return; end
            m2u_pkg::CC_BANK_LSB: begin bank_lo[ch] = b2; return; end
            m2u_pkg::CC_NRPN_MSB: begin par_rpn[ch] = 0; par_hi[ch] = b2; return; end
            m2u_pkg::CC_NRPN_LSB: begin par_rpn[ch] = 0; par_lo[ch] = b2; return; end
            m2u_pkg::CC_RPN_MSB: begin par_rpn[ch] = 1; par_hi[ch] = b2; return; end
            m2u_pkg::CC_RPN_LSB: begin par_rpn[ch] = 1; par_lo[ch] = b2; return; end
            m2u_pkg::CC_DATA_MSB: begin
              if (par_hi[ch] == m2u_pkg::UNSET || par_lo[ch] == m2u_pkg::UNSET) return;
              // pitch bend range (RPN 0/0) and RPN 0/6 send on MSB alone
              if (par_rpn[ch] && par_hi[ch] == 0 &&
                  (par_lo[ch] == 0 || par_lo[ch] == m2u_pkg::CC_DATA_MSB))
                param_emit(ch, {b2[6:0], 7'h0});
              else val_hi[ch] = b2;
              return;
            end
            m2u_pkg::CC_DATA_LSB: begin
              hi = (val_hi[ch] == m2u_pkg::UNSET) ? 7'h0 : val_hi[ch][6:0];
              if (par_hi[ch] == m2u_pkg::UNSET || par_lo[ch] == m2u_pkg::UNSET) return;
              param_emit(ch, {hi, b2[6:0]});
              return;
            end
            default: begin
              w0 |= {16'h0, b1, 8'h0};
              w1 = scale(b2, 7, 32);
            end
          endcase
        end
      endcase
      push2(w0, w1);
    endfunction

    // Note one accepted stream byte.
    function void note_byte(logic [7:0] b);
      logic [7:0] rs, d1;
      rs = run_status;
      if (b == m2u_pkg::B_TUNE || b >= m2u_pkg::B_CLOCK) begin
        convert(b, 8'd0, 8'd0);
        return;
      end
      if (b[7]) begin
        run_status = b; held = m2u_pkg::UNSET;
        if (b == m2u_pkg::B_SX_START) begin
          sx_phase = m2u_pkg::PH_FIRST; sx_cnt = 0;
          for (int i = 0; i < 6; i++) sx_buf[i] = 0;
        end else if (b == m2u_pkg::B_SX_STOP) begin
          sx_emit(sx_phase == m2u_pkg::PH_FIRST ? m2u_pkg::SX_COMPLETE : m2u_pkg::SX_END,
                  sx_cnt[3:0]);
          sx_phase = m2u_pkg::PH_IDLE;
        end
        return;
      end
      if (sx_phase != m2u_pkg::PH_IDLE) begin
        if (sx_cnt >= 6) begin
          sx_emit({2'b0, sx_phase}, 4'd6);
          sx_phase = m2u_pkg::PH_CONT; sx_cnt = 0;
        end
        sx_buf[sx_cnt] = b[6:0];
        sx_cnt++;
        return;
      end
      if (held != m2u_pkg::UNSET) begin
        d1 = held; held = m2u_pkg::UNSET;
        convert(rs, d1, b);
        return;
      end
      if (rs != 0) begin
        if (rs[7:4] == m2u_pkg::ST_PROGRAM || rs[7:4] == m2u_pkg::ST_CHAN_AT ||
            rs == m2u_pkg::B_MTC || rs == m2u_pkg::B_SONG_SEL)
          convert(rs, b, 8'd0);
        else if (rs < m2u_pkg::B_SX_START || rs == m2u_pkg::B_SONG_POS) held = b;
      end
    endfunction

    // Check one accepted UMP word.
    function void check_word(logic [31:0] w, logic lw);
      logic [32:0] e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h last %b", w, lw);
        return;
      end
      e = pending.pop_front();
      if (e[31:0] !== w || e[32] !== lw) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h last %b, got %h last %b", e[31:0], e[32], w, lw);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #10 clk = ~clk;

  m2u_byte_if src ();
  m2u_ump_if  ump ();
  m2u_cfg_if  cfg ();

  midi1_bytestream_to_ump DUT (.clk(clk), .rst(rst), .src(src), .ump(ump), .cfg(cfg));

  ump_scoreboard sb = new();
  bit quiet;   // no idling in the closing stretch
  int stall_left;

  // Output side: random stall bursts, sampled at the rising edge.
  initial ump.ready = 0;
  always @(negedge clk) begin
    if (rst || quiet) ump.ready <= 1;
    else if (stall_left > 0) begin
      ump.ready <= 0;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      ump.ready <= 0;
      stall_left = $urandom_range(0, 7);
    end else ump.ready <= 1;
  end

  always @(posedge clk)
    if (!rst && ump.valid && ump.ready) sb.check_word(ump.ump_word, ump.last_word);

  // valid stays high between back-to-back bytes; it drops on a gap or in drain
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      src.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    src.valid <= 1;
    src.in_byte <= b;
    @(posedge clk);
    while (!src.ready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic drain();
    src.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_mode(input bit m2, input logic [3:0] grp);
    drain();
    write_reg(m2u_pkg::REG_MIDI2_OUT, {7'h0, m2});
    write_reg(m2u_pkg::REG_GROUP, {4'h0, grp});
    cfg.valid <= 0;
  endtask

  // A message with random content, sometimes using running status, or a noise byte.
  task automatic send_message();
    logic [7:0] ch, cc;
    int kind;
    ch = 8'($urandom_range(0, 15));
    kind = $urandom_range(0, 13);
    case (kind)
      0, 1: begin
        send_byte({m2u_pkg::ST_NOTE_ON, ch[3:0]});
        send_byte(8'($urandom_range(0, 127)));
        send_byte($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(0, 127)));
      end
      2: begin
        send_byte({4'h8 + 4'($urandom_range(0, 6)), ch[3:0]});
        send_byte(8'($urandom_range(0, 127)));
        send_byte(8'($urandom_range(0, 127)));
      end
      3, 4: begin
        // RPN/NRPN controller sequence
        cc = $urandom_range(0, 1) ? m2u_pkg::CC_RPN_MSB : m2u_pkg::CC_NRPN_MSB;
        send_byte({m2u_pkg::ST_CTRL, ch[3:0]});
        send_byte(cc);
        send_byte($urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom_range(0, 127)));
        send_byte(cc - 8'd1); send_byte(8'($urandom_range(0, 7)));
        send_byte(m2u_pkg::CC_DATA_MSB); send_byte(8'($urandom_range(0, 127)));
        if ($urandom_range(0, 1)) begin
          send_byte(m2u_pkg::CC_DATA_LSB); send_byte(8'($urandom_range(0, 127)));
        end
      end
      5: begin
        send_byte({m2u_pkg::ST_CTRL, ch[3:0]});
        send_byte(m2u_pkg::CC_BANK_MSB); send_byte(8'($urandom_range(0, 127)));
        send_byte(m2u_pkg::CC_BANK_LSB); send_byte(8'($urandom_range(0, 127)));
        send_byte({m2u_pkg::ST_PROGRAM, ch[3:0]}); send_byte(8'($urandom_range(0, 127)));
      end
      6: begin
        send_byte({$urandom_range(0, 1) ? m2u_pkg::ST_PROGRAM : m2u_pkg::ST_CHAN_AT,
                   ch[3:0]});
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 127)));
      end
      7, 8: begin
        send_byte(m2u_pkg::B_SX_START);
        repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 127)));
        if ($urandom_range(0, 3) == 0) send_byte(m2u_pkg::B_CLOCK);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 127)));
        send_byte(m2u_pkg::B_SX_STOP);
      end
      9: begin
        send_byte(m2u_pkg::B_SONG_POS);
        repeat (2 * $urandom_range(1, 2)) send_byte(8'($urandom_range(0, 127)));
      end
      10: begin
        send_byte($urandom_range(0, 1) ? m2u_pkg::B_MTC : m2u_pkg::B_SONG_SEL);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 127)));
      end
      11: send_byte($urandom_range(0, 1) ? m2u_pkg::B_TUNE :
                    8'($urandom_range(8'hF8, 8'hFF)));
      default: send_byte(8'($urandom_range(0, 255)));   // noise
    endcase
  endtask

  initial begin
    src.valid = 0; src.in_byte = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    quiet = 0; stall_left = 0;
    sb.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: data without status, stray end, system and realtime, note on, bend, SysEx.
    send_byte(8'h00); send_byte(8'h7F); send_byte(m2u_pkg::B_SX_STOP);
    send_byte(8'hFF); send_byte(m2u_pkg::B_TUNE); send_byte(8'hF9);
    send_byte(8'hF4); send_byte(8'h55);
    send_byte(8'h90); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h40); send_byte(8'h00);
    send_byte(8'hEF); send_byte(8'h7F); send_byte(8'h00);
    send_byte(m2u_pkg::B_SX_START); send_byte(8'h7F); send_byte(m2u_pkg::B_SX_STOP);
    set_mode(1, 4'hF);
    // unset parameter entry, then RPN 0/0 via data MSB alone and LSB, then program and bend
    send_byte(8'hB3); send_byte(m2u_pkg::CC_DATA_MSB); send_byte(8'h40);
    send_byte(m2u_pkg::CC_DATA_LSB); send_byte(8'h10);
    send_byte(m2u_pkg::CC_RPN_MSB); send_byte(8'h00);
    send_byte(m2u_pkg::CC_RPN_LSB); send_byte(8'h00);
    send_byte(m2u_pkg::CC_DATA_MSB); send_byte(8'h7F);
    send_byte(m2u_pkg::CC_DATA_LSB); send_byte(8'h7F);
    send_byte(8'hC3); send_byte(8'h05);
    send_byte(8'hE0); send_byte(8'h7F); send_byte(8'h7F);

    // Hold off until every expected word has arrived.
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_mode(0, 4'h0);
        1: set_mode(1, 4'($urandom_range(1, 14)));
        2: set_mode(0, 4'hF);
        default: set_mode(1, 4'($urandom_range(0, 15)));
      endcase
      if (phase == 3) quiet = 1;
      repeat (60) send_message();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
